// ----- rtl/frustum_cull_test_unit_defines.svh -----
// ---------------------------------------------------------------------------
// frustum cull test unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk and idle in reset.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH
`define FRUSTUM_CULL_TEST_UNIT_DEFINES_SVH

// overlapping implication
`define FCULL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define FCULL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ----- rtl/fcull_pkg.sv -----
// ---------------------------------------------------------------------------
// fcull_pkg
// Types, widths and codes shared by the frustum cull test unit.
// ---------------------------------------------------------------------------
package fcull_pkg;

    localparam int NumPlanes = 6;
    localparam int CoordW    = 24;
    localparam int CoefW     = 12;
    localparam int DistW     = 28;
    localparam int RadW      = 23;
    localparam int CmdW      = 2;
    localparam int CfgDataW  = 64;
    localparam int CfgIdxW   = $clog2(NumPlanes);
    localparam int ProdW     = CoefW + CoordW;
    localparam int SumW      = ProdW + 4;
    // d is Q.8 and the products are Q.18
    localparam int FracShift = 10;

    // object kinds
    localparam logic [CmdW-1:0] CMD_BOX    = 2'd0;
    localparam logic [CmdW-1:0] CMD_SPHERE = 2'd1;
    localparam logic [CmdW-1:0] CMD_POINT  = 2'd2;
    localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    // layout matches the configuration word: d in the top bits, a at the bottom
    typedef struct packed {
        logic signed [DistW-1:0] d;
        logic signed [CoefW-1:0] c;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] a;
    } t_plane;

    typedef struct packed {
        logic                     en;
        logic [CfgIdxW-1:0]       index;
        logic [CfgDataW-1:0]      data;
    } t_cfg_wr;

    typedef struct packed {
        logic is_box;
        logic is_sphere;
    } t_lane_ctl;

    // corner of the box furthest along the normal on one axis;
    // other objects use the first coordinate as is
    function automatic t_coord pick_vertex(
        input logic                    is_box,
        input logic signed [CoefW-1:0] coef,
        input t_coord                  lo,
        input t_coord                  hi
    );
        logic hi_bigger;
        hi_bigger = (hi > lo);
        if (!is_box) begin
            return lo;
        end else if (!coef[CoefW-1]) begin
            return hi_bigger ? hi : lo;
        end else begin
            return hi_bigger ? lo : hi;
        end
    endfunction

endpackage

// ----- rtl/fcull_plane_regs.sv -----
// ---------------------------------------------------------------------------
// fcull_plane_regs
// The six plane registers, written through the configuration channel.
// ---------------------------------------------------------------------------
module fcull_plane_regs
    import fcull_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_wr,
    output t_plane  o_planes [NumPlanes]
);

    t_plane r_planes [NumPlanes];

    // indexes past the last plane are dropped
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NumPlanes; p++) begin
            if (!i_rst_n) begin
                r_planes[p] <= '0;
            end else if (i_wr.en && (i_wr.index == CfgIdxW'(p))) begin
                r_planes[p] <= t_plane'(i_wr.data);
            end
        end
    end

    assign o_planes = r_planes;

endmodule

// ----- rtl/fcull_plane_lane.sv -----
// ---------------------------------------------------------------------------
// fcull_plane_lane
// Signed distance of one object against one plane, two register stages.
// ---------------------------------------------------------------------------
module fcull_plane_lane
    import fcull_pkg::*;
(
    input  logic            i_clk,
    input  t_plane          i_plane,
    input  t_lane_ctl       i_ctl,
    input  t_vec            i_lo,
    input  t_vec            i_hi,
    input  logic [RadW-1:0] i_radius,
    output logic            o_inside
);

    t_coord                  v_x, v_y, v_z;
    logic signed [SumW-1:0]  d_ext, rad_ext;
    logic signed [ProdW-1:0] n_px, n_py, n_pz;
    logic signed [SumW-1:0]  n_bias, n_sum;
    logic signed [ProdW-1:0] r_px, r_py, r_pz;
    logic signed [SumW-1:0]  r_bias, r_sum;

    // test vertex: box corner furthest inside, else the given point
    always_comb begin
        v_x = pick_vertex(i_ctl.is_box, i_plane.a, i_lo.x, i_hi.x);
        v_y = pick_vertex(i_ctl.is_box, i_plane.b, i_lo.y, i_hi.y);
        v_z = pick_vertex(i_ctl.is_box, i_plane.c, i_lo.z, i_hi.z);
    end

    // products, and d widened to Q.18 with the sphere radius folded in
    always_comb begin
        n_px    = i_plane.a * v_x;
        n_py    = i_plane.b * v_y;
        n_pz    = i_plane.c * v_z;
        d_ext   = SumW'(i_plane.d);
        rad_ext = SumW'(i_radius);
        n_bias  = (d_ext <<< FracShift)
                + (i_ctl.is_sphere ? (rad_ext <<< FracShift) : '0);
    end

    always_ff @(posedge i_clk) begin
        r_px   <= n_px;
        r_py   <= n_py;
        r_pz   <= n_pz;
        r_bias <= n_bias;
    end

    // distance sum
    assign n_sum = SumW'(r_px) + SumW'(r_py) + SumW'(r_pz) + r_bias;

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    // strictly positive counts as inside
    assign o_inside = !r_sum[SumW-1] && (r_sum != '0);

endmodule

// ----- rtl/frustum_cull_test_unit.sv -----
// ---------------------------------------------------------------------------
// frustum_cull_test_unit
// Box, sphere and point visibility against six configured frustum planes.
// ---------------------------------------------------------------------------
// One object is taken in every clock cycle while busy is low, and its
// visible flag comes out marked by o_valid for a single cycle;
// the receiver cannot stall, so every result must be taken as it appears.
// An object passes through the input register, the registered 12x24 products
// and the registered distance sum in each of the six plane lanes, and the
// result register. busy is high during reset and for the first cycle after
// it, and never otherwise. The user must let plane registers take writes
// only while no object is in flight; the block itself does not enforce it.
module frustum_cull_test_unit
    import fcull_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [CmdW-1:0]     i_command,
    input  t_coord              i_x_a,
    input  t_coord              i_y_a,
    input  t_coord              i_z_a,
    input  t_coord              i_x_b,
    input  t_coord              i_y_b,
    input  t_coord              i_z_b,
    input  logic [RadW-1:0]     i_radius,
    output logic                busy,
    output logic                o_valid,
    output logic                o_visible,
    input  logic                i_cfg_valid,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output logic                o_cfg_ready
);

`include "frustum_cull_test_unit_defines.svh"

    logic            r_busy;
    logic            r_a_valid, r_b_valid, r_c_valid, r_out_valid;
    logic [CmdW-1:0] r_a_cmd, r_b_cmd, r_c_cmd;
    t_vec            r_a_lo, r_a_hi;
    logic [RadW-1:0] r_a_rad;
    logic            r_visible, n_visible;
    logic            accept;
    t_cfg_wr         cfg_wr;
    t_plane          planes [NumPlanes];
    t_lane_ctl       lane_ctl;
    logic [NumPlanes-1:0] plane_pass;

    // ready flags come up in the cycle after reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign accept      = start && !r_busy;

    // configuration beat
    always_comb begin
        cfg_wr.en    = i_cfg_valid && !r_busy;
        cfg_wr.index = i_cfg_index;
        cfg_wr.data  = i_cfg_data;
    end

    fcull_plane_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cfg_wr),
        .o_planes (planes)
    );

    // input register
    always_ff @(posedge i_clk) begin
        r_a_cmd <= i_command;
        r_a_lo  <= '{x: i_x_a, y: i_y_a, z: i_z_a};
        r_a_hi  <= '{x: i_x_b, y: i_y_b, z: i_z_b};
        r_a_rad <= i_radius;
    end

    // valid and kind travel alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= accept;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cmd <= r_a_cmd;
        r_c_cmd <= r_b_cmd;
    end

    always_comb begin
        lane_ctl.is_box    = (r_a_cmd == CMD_BOX);
        lane_ctl.is_sphere = (r_a_cmd == CMD_SPHERE);
    end

    // one lane per plane
    for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
        fcull_plane_lane u_lane (
            .i_clk    (i_clk),
            .i_plane  (planes[p]),
            .i_ctl    (lane_ctl),
            .i_lo     (r_a_lo),
            .i_hi     (r_a_hi),
            .i_radius (r_a_rad),
            .o_inside (plane_pass[p])
        );
    end

    // visible only if every plane passes and the kind is a real one
    assign n_visible = (r_c_cmd != CMD_UNUSED) && (&plane_pass);

    always_ff @(posedge i_clk) begin
        r_visible <= n_visible;
    end

    assign o_valid   = r_out_valid;
    assign o_visible = r_visible;

    // checks
    `FCULL_ASSERT_IMP(a_latency, start && !busy, ##4 o_valid,
        "accepted object did not produce a result four cycles later")
    `FCULL_ASSERT_IMP(a_no_spurious, o_valid, $past(start && !busy, 4),
        "result strobe without a matching start beat")
    `FCULL_ASSERT_NEXT(a_unused_cmd, r_c_valid && (r_c_cmd == CMD_UNUSED),
        o_valid && !o_visible, "unused object kind reported visible")

endmodule
